[rtl/rsa_pkg.sv]
`timescale 1ns / 1ps
package rsa_pkg;

    localparam int MAX_OBSTACLES = 16;
    localparam int COORD_BITS    = 16;
    localparam int OBS_IDX_W     = $clog2(MAX_OBSTACLES);
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
    localparam int RAM_DEPTH     = MAX_OBSTACLES * 4;
    localparam int RAM_AW        = $clog2(RAM_DEPTH);
    localparam int EDGE_W        = COORD_BITS + 1;
    localparam int MUL_W         = COORD_BITS + EDGE_W;
    localparam int PROJ_W        = 2 * COORD_BITS + 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] LAST_CORNER = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } pt_t;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
    } proj_ctrl_t;

endpackage

[rtl/rsa_ram.sv]
`timescale 1ns / 1ps
module rsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/rsa_proj.sv]
`timescale 1ns / 1ps
module rsa_proj
    import rsa_pkg::*;
(
    input  logic                         clk,
    input  proj_ctrl_t                   ctrl,
    input  logic signed [COORD_BITS-1:0] opa,
    input  logic signed [EDGE_W-1:0]     opb,
    output logic signed [PROJ_W-1:0]     proj
);

    // x*ax, then y*ay while x*ax moves to acc, then proj = acc + prod
    logic signed [MUL_W-1:0]  prod_reg;
    logic signed [PROJ_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= opa * opb;
        end
        if (ctrl.acc_load)
        begin
            acc_reg <= PROJ_W'(prod_reg);
        end
    end

    assign proj = acc_reg + PROJ_W'(prod_reg);

endmodule

[rtl/rect_separating_axis_collide_top.sv]
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// command   in         start && !busy         operation slot corner coord_x coord_y
// result    out        hit_valid (1 cycle)    hit
// config    in         cfg_valid && cfg_ready cfg_data (obstacle_count)
//
// Load items and query corners 0..2 are stored when accepted. Query corner 3 runs the
// test on one shared multiplier: per obstacle a corner fetch from the corner RAM
// (S_LOAD), then per axis the edge normal (S_AX0, S_AX1), multiply, add and min/max
// for each of the 8 corners (S_MX, S_MY, S_MM), and a check (S_CHK).
// Count zero answers in the next cycle. Reset is asynchronous and needs no sweep.
// busy is high during a test; the result strobe cannot be stalled.
module rect_separating_axis_collide_top
    import rsa_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [3:0]                   slot,
    input  logic [1:0]                   corner,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         hit_valid,
    output logic                         hit,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [4:0]                   cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_AX0  = 3'd2;
    localparam logic [2:0] S_AX1  = 3'd3;
    localparam logic [2:0] S_MX   = 3'd4;
    localparam logic [2:0] S_MY   = 3'd5;
    localparam logic [2:0] S_MM   = 3'd6;
    localparam logic [2:0] S_CHK  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [2:0]       axis_reg, axis_next;
    logic [2:0]       j_reg, j_next;
    logic [4:0]       cfg_reg;
    logic             hit_valid_reg, hit_valid_next;
    logic             hit_reg, hit_next;

    pt_t                      q_reg [4];
    pt_t                      ob_reg [4];
    pt_t                      tmp_reg;
    logic signed [EDGE_W-1:0] ax_reg, ay_reg;
    logic signed [PROJ_W-1:0] lo_reg [2];
    logic signed [PROJ_W-1:0] hi_reg [2];

    logic             accept;
    logic [CNT_W-1:0] count_eff;
    logic [2:0]       sel_idx;
    pt_t              sel_pt;
    logic             ram_we;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    pt_t              ram_rdata;
    pt_t              in_pt;
    proj_ctrl_t       pctrl;
    logic signed [COORD_BITS-1:0] opa;
    logic signed [EDGE_W-1:0]     opb;
    logic signed [PROJ_W-1:0]     proj;
    logic             sep;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;
    assign in_pt     = '{y: coord_y, x: coord_x};

    assign count_eff = (CNT_W'(cfg_reg) > CNT_W'(MAX_OBSTACLES))
                       ? CNT_W'(MAX_OBSTACLES) : CNT_W'(cfg_reg);

    assign ram_we    = accept && (operation == OP_LOAD)
                       && (CNT_W'(slot) < CNT_W'(MAX_OBSTACLES));
    assign ram_waddr = {slot[OBS_IDX_W-1:0], corner};
    assign ram_raddr = {k_reg[OBS_IDX_W-1:0], cnt_reg[1:0]};

    rsa_ram #(
        .WIDTH ($bits(pt_t)),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_pt),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // single corner read port: bit 2 picks obstacle over query
    always_comb
    begin
        case (state_reg)
            S_AX0:   sel_idx = {axis_reg[0], axis_reg[2:1]};
            S_AX1:   sel_idx = {axis_reg[0], axis_reg[2:1] + 2'd1};
            default: sel_idx = j_reg;
        endcase
        sel_pt = sel_idx[2] ? ob_reg[sel_idx[1:0]] : q_reg[sel_idx[1:0]];
    end

    always_comb
    begin
        pctrl.mul_en   = (state_reg == S_MX) || (state_reg == S_MY);
        pctrl.acc_load = (state_reg == S_MY);
        opa = (state_reg == S_MY) ? sel_pt.y : sel_pt.x;
        opb = (state_reg == S_MY) ? ay_reg : ax_reg;
    end

    rsa_proj u_proj (
        .clk  (clk),
        .ctrl (pctrl),
        .opa  (opa),
        .opb  (opb),
        .proj (proj)
    );

    assign sep = (hi_reg[0] < lo_reg[1]) || (hi_reg[1] < lo_reg[0]);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        j_next         = j_reg;
        hit_valid_next = 1'b0;
        hit_next       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == OP_QUERY) && (corner == LAST_CORNER))
                begin
                    if (count_eff == '0)
                    begin
                        hit_valid_next = 1'b1;
                    end
                    else
                    begin
                        k_next     = '0;
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    axis_next  = '0;
                    state_next = S_AX0;
                end
            end
            S_AX0:
            begin
                state_next = S_AX1;
            end
            S_AX1:
            begin
                j_next     = '0;
                state_next = S_MX;
            end
            S_MX:
            begin
                state_next = S_MY;
            end
            S_MY:
            begin
                state_next = S_MM;
            end
            S_MM:
            begin
                j_next     = j_reg + 3'd1;
                state_next = (j_reg == 3'd7) ? S_CHK : S_MX;
            end
            S_CHK:
            begin
                if (sep)
                begin
                    if (k_reg + CNT_W'(1) == count_eff)
                    begin
                        hit_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                end
                else if (axis_reg == 3'd7)
                begin
                    hit_valid_next = 1'b1;
                    hit_next       = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    axis_next  = axis_reg + 3'd1;
                    state_next = S_AX0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            cnt_reg       <= '0;
            axis_reg      <= '0;
            j_reg         <= '0;
            cfg_reg       <= '0;
            hit_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            j_reg         <= j_next;
            hit_valid_reg <= hit_valid_next;
            hit_reg       <= hit_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_QUERY))
        begin
            q_reg[corner] <= in_pt;
        end
        if ((state_reg == S_LOAD) && (cnt_reg != 3'd0))
        begin
            ob_reg[cnt_reg[1:0] - 2'd1] <= ram_rdata;
        end
        if (state_reg == S_AX0)
        begin
            tmp_reg <= sel_pt;
        end
        if (state_reg == S_AX1)
        begin
            // normal of edge tmp - next: (-(tmp.y - next.y), tmp.x - next.x)
            ax_reg <= EDGE_W'(sel_pt.y) - EDGE_W'(tmp_reg.y);
            ay_reg <= EDGE_W'(tmp_reg.x) - EDGE_W'(sel_pt.x);
        end
        if (state_reg == S_MM)
        begin
            if (j_reg[1:0] == 2'd0)
            begin
                lo_reg[j_reg[2]] <= proj;
                hi_reg[j_reg[2]] <= proj;
            end
            else
            begin
                if (proj < lo_reg[j_reg[2]])
                begin
                    lo_reg[j_reg[2]] <= proj;
                end
                if (proj > hi_reg[j_reg[2]])
                begin
                    hi_reg[j_reg[2]] <= proj;
                end
            end
        end
    end

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid |-> ($past(state_reg) == S_CHK) || ($past(accept)
            && ($past(operation) == OP_QUERY) && ($past(corner) == LAST_CORNER)))
        else $error("result without a finished test");

    a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_QUERY) && (corner == LAST_CORNER)
            && (count_eff != '0)) |=> busy)
        else $error("test did not start");

    a_check_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> ($past(state_reg) == S_MM))
        else $error("axis check without projections");

    a_hit_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> hit_valid)
        else $error("hit outside strobe");

endmodule

[tb/rect_separating_axis_collide_top_test.sv]
`timescale 1ns / 1ps
module rect_separating_axis_collide_top_test;
    import rsa_pkg::*;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         operation;
    logic [3:0]                   slot;
    logic [1:0]                   corner;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic                         hit_valid;
    logic                         hit;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [4:0]                   cfg_data;

    rect_separating_axis_collide_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .slot(slot), .corner(corner),
        .coord_x(coord_x), .coord_y(coord_y),
        .hit_valid(hit_valid), .hit(hit),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    typedef struct {
        logic        op;
        logic [3:0]  sl;
        logic [1:0]  cn;
        logic [15:0] x;
        logic [15:0] y;
        int          want;   // -1: use predictor
    } stim_t;

    longint obs_x [RAM_DEPTH];
    longint obs_y [RAM_DEPTH];
    longint qry_x [4];
    longint qry_y [4];
    bit     obs_written [RAM_DEPTH];
    int     active_count;
    bit     hits_pending [$];
    int     errors;
    int     hit_results;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    initial
    begin
        #80ms;
        $display("rect_separating_axis_collide_top_test NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic bit axis_overlap(input longint ax, input longint ay, input int base);
        longint alo, ahi, blo, bhi, p;
        alo = qry_x[0] * ax + qry_y[0] * ay;
        ahi = alo;
        blo = obs_x[base] * ax + obs_y[base] * ay;
        bhi = blo;
        for (int i = 1; i < 4; i++)
        begin
            p = qry_x[i] * ax + qry_y[i] * ay;
            if (p < alo) alo = p;
            if (p > ahi) ahi = p;
            p = obs_x[base + i] * ax + obs_y[base + i] * ay;
            if (p < blo) blo = p;
            if (p > bhi) bhi = p;
        end
        return !(ahi < blo || bhi < alo);
    endfunction

    function automatic bit rect_hits_obstacle(input int k);
        int n;
        int b;
        b = k * 4;
        for (int i = 0; i < 4; i++)
        begin
            n = (i + 1) % 4;
            if (!axis_overlap(-(qry_y[i] - qry_y[n]), qry_x[i] - qry_x[n], b)) return 0;
            if (!axis_overlap(-(obs_y[b + i] - obs_y[b + n]),
                              obs_x[b + i] - obs_x[b + n], b)) return 0;
        end
        return 1;
    endfunction

    function automatic int predict_hit(input stim_t s);
        int cnt;
        longint px, py;
        px = $signed(s.x);
        py = $signed(s.y);
        if (s.op == OP_LOAD)
        begin
            obs_x[s.sl * 4 + s.cn] = px;
            obs_y[s.sl * 4 + s.cn] = py;
            obs_written[s.sl * 4 + s.cn] = 1;
            return -1;
        end
        qry_x[s.cn] = px;
        qry_y[s.cn] = py;
        if (s.cn != LAST_CORNER) return -1;
        cnt = active_count > MAX_OBSTACLES ? MAX_OBSTACLES : active_count;
        for (int k = 0; k < cnt; k++)
            if (rect_hits_obstacle(k)) return 1;
        return 0;
    endfunction

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        repeat (g) @(negedge clk);
    endtask

    task automatic send_item(input stim_t s);
        int p;
        p = predict_hit(s);
        if (s.want >= 0 && p != s.want)
            report_mismatch($sformatf("predictor gives %0d, table says %0d", p, s.want));
        operation = s.op;
        slot      = s.sl;
        corner    = s.cn;
        coord_x   = s.x;
        coord_y   = s.y;
        start     = 1'b1;
        do @(posedge clk); while (busy);
        if (p >= 0) hits_pending.insert(hits_pending.size(), p[0]);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (hits_pending.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4000) @(negedge clk);
    endtask

    task automatic write_count(input int v);
        cfg_data  = v[4:0];
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        active_count = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic stim_t mk(input logic op, input int sl, input int cn,
                                 input int x, input int y, input int want);
        stim_t s;
        s.op = op; s.sl = sl[3:0]; s.cn = cn[1:0]; s.x = x[15:0]; s.y = y[15:0];
        s.want = want;
        return s;
    endfunction

    task automatic load_box(input int sl, input int x0, input int y0,
                            input int x1, input int y1);
        send_item(mk(OP_LOAD, sl, 0, x0, y0, -1));
        send_item(mk(OP_LOAD, sl, 1, x1, y0, -1));
        send_item(mk(OP_LOAD, sl, 2, x1, y1, -1));
        send_item(mk(OP_LOAD, sl, 3, x0, y1, -1));
    endtask

    function automatic int rnd_coord(input int span);
        int c;
        if (span == 0) return $urandom_range(0, 65535);
        c = $urandom_range(0, 2 * span) - span;
        return c;
    endfunction

    task automatic random_shape(input logic op, input int sl, input int span);
        int cx, cy, hw, hh, dx, dy;
        bit wild;
        wild = ($urandom_range(0, 9) == 0);
        cx = rnd_coord(span);
        cy = rnd_coord(span);
        hw = $urandom_range(0, span / 4 + 1);
        hh = $urandom_range(0, span / 4 + 1);
        dx = $urandom_range(0, hw);
        dy = $urandom_range(0, hh);
        for (int c = 0; c < 4; c++)
        begin
            int x, y;
            case (c)
                0: begin x = cx - hw + dy; y = cy - hh - dx; end
                1: begin x = cx + hw + dy; y = cy - hh + dx; end
                2: begin x = cx + hw - dy; y = cy + hh + dx; end
                default: begin x = cx - hw - dy; y = cy + hh - dx; end
            endcase
            if (wild)
            begin
                x = $urandom_range(0, 65535);
                y = $urandom_range(0, 65535);
            end
            send_item(mk(op, sl, c, x, y, -1));
            random_gap();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && hit_valid)
        begin
            if (hits_pending.size() == 0)
                report_mismatch("unexpected hit result");
            else
            begin
                bit w;
                w = hits_pending.pop_front();
                hit_results++;
                if (hit !== w)
                    report_mismatch($sformatf("hit %b, expected %b", hit, w));
            end
        end
    end

    stim_t directed [$];

    initial
    begin
        int counts [6];
        errors = 0;
        hit_results = 0;
        active_count = 0;
        for (int i = 0; i < RAM_DEPTH; i++)
        begin
            obs_x[i] = 0; obs_y[i] = 0; obs_written[i] = 0;
        end
        for (int i = 0; i < 4; i++)
        begin
            qry_x[i] = 0; qry_y[i] = 0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_LOAD;
        slot = '0;
        corner = '0;
        coord_x = '0;
        coord_y = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // count zero after reset: no obstacle is read
        directed.insert(directed.size(), mk(OP_QUERY, 0, 0, 16'h8000, 16'h8000, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 1, 16'h7fff, 16'h8000, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 2, 16'h7fff, 16'h7fff, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 3, 16'h8000, 16'h7fff, 0));
        foreach (directed[i]) send_item(directed[i]);
        drain();

        // fill every slot: far extremes, a touching box, a degenerate point
        for (int s = 0; s < MAX_OBSTACLES; s++)
            load_box(s, 20000 + s, 20000, 20100 + s, 20100);
        load_box(0, 16'h8000, 16'h8000, 16'h8010, 16'h8010);
        load_box(1, 100, 100, 200, 200);
        load_box(2, 300, 300, 300, 300);
        write_count(MAX_OBSTACLES);
        directed.delete();
        directed.insert(directed.size(), mk(OP_QUERY, 0, 0, 0, 0, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 1, 100, 0, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 2, 100, 100, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 3, 0, 100, 1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 0, 16'h7ff0, 16'h7ff0, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 1, 16'h7fff, 16'h7ff0, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 2, 16'h7fff, 16'h7fff, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 3, 16'h7ff0, 16'h7fff, 0));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 0, 16'h8000, 16'h8000, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 3, 16'h8000, 16'h8000, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 0, 250, 250, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 1, 350, 250, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 2, 350, 350, -1));
        directed.insert(directed.size(), mk(OP_QUERY, 0, 3, 250, 350, 1));
        foreach (directed[i]) send_item(directed[i]);
        drain();
        write_count(31);
        send_item(mk(OP_QUERY, 0, 3, 16'h8000, 16'h8000, -1));
        drain();

        counts = '{1, 3, 2, 16, 0, 31};
        for (int ph = 0; ph < 6; ph++)
        begin
            int span;
            drain();
            write_count(counts[ph]);
            span = (ph % 2) ? 400 : 4000;
            for (int s = 0; s < MAX_OBSTACLES; s++)
                random_shape(OP_LOAD, s, span);
            for (int q = 0; q < 32; q++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    int s;
                    s = $urandom_range(0, MAX_OBSTACLES - 1);
                    random_shape(OP_LOAD, s, span);
                end
                random_shape(OP_QUERY, 0, span);
                if ($urandom_range(0, 7) == 0)
                    send_item(mk(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 3),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535), -1));
                if (q == 20)
                    while (hits_pending.size() != 0) @(negedge clk);
            end
        end

        drain();
        if (errors == 0 && hits_pending.size() == 0)
            $display("rect_separating_axis_collide_top_test OK");
        else
            $display("rect_separating_axis_collide_top_test NOT OK");
        $finish;
    end
endmodule
